// ===== rtl/core/hbfv_pkg.sv =====
// ----------------------------------------------------------------------------
// hbfv_pkg
// Shared types and constants of the hashed byte feature vector block.
// ----------------------------------------------------------------------------
package hbfv_pkg;

	localparam int FC_W       = 7;
	localparam int BYTE_W     = 8;
	localparam int FI_W       = 6;
	localparam int FV_W       = 16;
	localparam int HASH_W     = 16;
	localparam int DIV_STEPS  = 16;

	localparam logic [FC_W-1:0]   FC_RESET = 7'd64;
	localparam logic [HASH_W-1:0] HASH_MUL = 16'd131;
	localparam logic [HASH_W-1:0] HASH_ADD = 16'd17;
	localparam logic [FV_W:0]     ONE_Q15  = 17'd32768;

	typedef enum logic {
		OPC_BYTE   = 1'b0,
		OPC_FINISH = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_RD,
		ST_UPD,
		ST_SQ_RD,
		ST_SQ_MUL,
		ST_SQ_ACC,
		ST_SQ_LOAD,
		ST_SQRT,
		ST_EM_RD,
		ST_EM_LOAD,
		ST_DIV,
		ST_EM_OUT
	} state_t;

endpackage

// ===== rtl/core/hashed_byte_feature_vector_top.sv =====
// Byte item: two passes of 16 modulo steps, read and write, busy meanwhile.
// Finish item: per active bucket a read, multiply and accumulate for the square sum,
// then a load and the square root steps, then per bucket read, load, 16 division
// steps (skipped for an all-zero vector) and output transfer, held by output stall.
// All iterative steps run through one shared compare/subtract unit.
// Async reset idles the sequencer, clears bucket valid bits, sets feature_count to 64.
// ----------------------------------------------------------------------------
// hashed_byte_feature_vector_top
// Hashes prompt bytes into half-unit buckets and emits the L2-normalized
// vector in Q1.15 on a finish item.
// ----------------------------------------------------------------------------
module hashed_byte_feature_vector_top #(
	parameter int MAX_FEATURES = 64,
	parameter int COUNT_BITS   = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_en,
	input  logic [hbfv_pkg::FC_W-1:0]   cfg_write_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        opcode,
	input  logic [hbfv_pkg::BYTE_W-1:0] byte_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [hbfv_pkg::FI_W-1:0]   feature_index,
	output logic [hbfv_pkg::FV_W-1:0]   feature_value,
	output logic                        last_feature
);

	import hbfv_pkg::*;

	localparam int IDX_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
	localparam int CNT_W   = $clog2(MAX_FEATURES + 1) + 1;
	localparam int SUM_W   = 2 * COUNT_BITS + $clog2(MAX_FEATURES);
	localparam int SQ_W    = (SUM_W > 64) ? 64 : SUM_W;
	localparam int R_W     = (SQ_W + 1) / 2;
	localparam int SH_W    = 2 * R_W;
	localparam int U_W     = R_W + 3;
	localparam int NUM_W   = ((COUNT_BITS + 15 > R_W) ? COUNT_BITS + 15 : R_W) + 1;
	localparam int STEP_W  = $clog2(((R_W > DIV_STEPS) ? R_W : DIV_STEPS) + 1);
	localparam logic [FC_W-1:0] MAX_FC = FC_W'(MAX_FEATURES);

	state_t state_q, state_d;

	logic [FC_W-1:0]       fc_q;
	logic [MAX_FEATURES-1:0] vld_q;
	logic [BYTE_W-1:0]     byte_q;
	logic                  hash_sel_q;
	logic [CNT_W-1:0]      pos_q;
	logic [STEP_W-1:0]     step_q;
	logic [R_W:0]          rem_q;
	logic [R_W-1:0]        root_q;
	logic [SH_W-1:0]       shift_q;
	logic [2*COUNT_BITS-1:0] sq_q;
	logic [SUM_W-1:0]      acc_q;
	logic [FV_W-1:0]       out_value_q;

	logic [FC_W-1:0]       n7;
	logic [CNT_W-1:0]      n_act;
	logic                  pos_last;
	logic                  step_done;
	logic                  in_xfer;
	logic [HASH_W-1:0]     hash2;
	logic [IDX_W-1:0]      rd_addr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS:0]   sat_sum;
	logic [COUNT_BITS-1:0] cnt_new;
	logic                  ram_we;
	logic [SUM_W-1:0]      sq_lim;
	logic [SQ_W-1:0]       s_in;
	logic [NUM_W-1:0]      num;

	// shared compare/subtract unit
	logic [U_W-1:0]        ua, ub;
	logic [U_W:0]          diff;
	logic                  ge;
	logic [R_W:0]          rem_next;

	assign n7 = (fc_q == '0) ? FC_W'(1) : ((fc_q > MAX_FC) ? MAX_FC : fc_q);
	assign n_act = CNT_W'(n7);
	assign pos_last = ((pos_q + CNT_W'(1)) == n_act);
	assign step_done = (step_q == '0);
	assign in_stall = (state_q != ST_IDLE);
	assign in_xfer = in_valid && !in_stall;
	assign hash2 = HASH_W'(byte_q) * HASH_MUL + HASH_ADD;

	assign rd_addr = (state_q == ST_RD || state_q == ST_UPD) ? rem_q[IDX_W-1:0]
	                                                         : pos_q[IDX_W-1:0];
	assign cnt = vld_q[rd_addr] ? ram_rdata : '0;
	assign sat_sum = {1'b0, cnt} + (COUNT_BITS + 1)'(hash_sel_q ? 2'd1 : 2'd2);
	assign cnt_new = sat_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sat_sum[COUNT_BITS-1:0];
	assign ram_we = (state_q == ST_UPD);

	assign sq_lim = SUM_W'({SQ_W{1'b1}});
	assign s_in = (acc_q > sq_lim) ? {SQ_W{1'b1}} : acc_q[SQ_W-1:0];
	assign num = (NUM_W'(cnt) << 15) + NUM_W'(root_q >> 1);

	hbfv_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(MAX_FEATURES),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(rem_q[IDX_W-1:0]),
		.wdata(cnt_new),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		ua = '0;
		ub = '0;
		unique case (state_q)
			ST_MOD: begin
				ua = U_W'({rem_q[CNT_W-1:0], shift_q[SH_W-1]});
				ub = U_W'(n_act);
			end
			ST_SQRT: begin
				ua = {rem_q, shift_q[SH_W-1 -: 2]};
				ub = U_W'({root_q, 2'b01});
			end
			ST_DIV: begin
				ua = U_W'({rem_q[R_W-1:0], shift_q[SH_W-1]});
				ub = U_W'(root_q);
			end
			default: begin
				ua = '0;
				ub = '0;
			end
		endcase
		diff = {1'b0, ua} - {1'b0, ub};
		ge = !diff[U_W];
		rem_next = ge ? diff[R_W:0] : ua[R_W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (opcode == OPC_FINISH) ? ST_SQ_RD : ST_MOD;
				end
			end
			ST_MOD:     if (step_done) state_d = ST_RD;
			ST_RD:      state_d = ST_UPD;
			ST_UPD:     state_d = hash_sel_q ? ST_IDLE : ST_MOD;
			ST_SQ_RD:   state_d = ST_SQ_MUL;
			ST_SQ_MUL:  state_d = ST_SQ_ACC;
			ST_SQ_ACC:  state_d = pos_last ? ST_SQ_LOAD : ST_SQ_RD;
			ST_SQ_LOAD: state_d = ST_SQRT;
			ST_SQRT:    if (step_done) state_d = ST_EM_RD;
			ST_EM_RD:   state_d = ST_EM_LOAD;
			ST_EM_LOAD: state_d = (root_q == '0) ? ST_EM_OUT : ST_DIV;
			ST_DIV:     if (step_done) state_d = ST_EM_OUT;
			ST_EM_OUT: begin
				if (!out_stall) begin
					state_d = pos_last ? ST_IDLE : ST_EM_RD;
				end
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q  <= FC_RESET;
			vld_q <= '0;
		end else begin
			if (cfg_write_en) begin
				fc_q <= cfg_write_data;
			end
			if (ram_we) begin
				vld_q[rem_q[IDX_W-1:0]] <= 1'b1;
			end else if (state_q == ST_EM_OUT && !out_stall && pos_last) begin
				vld_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				byte_q     <= byte_value;
				hash_sel_q <= 1'b0;
				rem_q      <= '0;
				shift_q    <= SH_W'(byte_value) << (SH_W - HASH_W);
				step_q     <= STEP_W'(DIV_STEPS - 1);
				pos_q      <= '0;
				acc_q      <= '0;
			end
			ST_MOD, ST_DIV: begin
				rem_q   <= rem_next;
				shift_q <= {shift_q[SH_W-2:0], ge};
				step_q  <= step_q - STEP_W'(1);
				if (state_q == ST_DIV && step_done) begin
					out_value_q <= {shift_q[FV_W-2:0], ge};
				end
			end
			ST_UPD: begin
				hash_sel_q <= 1'b1;
				rem_q      <= '0;
				shift_q    <= SH_W'(hash2) << (SH_W - HASH_W);
				step_q     <= STEP_W'(DIV_STEPS - 1);
			end
			ST_SQ_MUL: begin
				sq_q <= (2 * COUNT_BITS)'(cnt) * (2 * COUNT_BITS)'(cnt);
			end
			ST_SQ_ACC: begin
				acc_q <= acc_q + SUM_W'(sq_q);
				if (!pos_last) begin
					pos_q <= pos_q + CNT_W'(1);
				end
			end
			ST_SQ_LOAD: begin
				shift_q <= SH_W'(s_in);
				rem_q   <= '0;
				root_q  <= '0;
				step_q  <= STEP_W'(R_W - 1);
			end
			ST_SQRT: begin
				rem_q   <= rem_next;
				root_q  <= {root_q[R_W-2:0], ge};
				shift_q <= shift_q << 2;
				step_q  <= step_q - STEP_W'(1);
				if (step_done) begin
					pos_q <= '0;
				end
			end
			ST_EM_LOAD: begin
				rem_q       <= (R_W + 1)'(num >> DIV_STEPS);
				shift_q     <= SH_W'(num[DIV_STEPS-1:0]) << (SH_W - DIV_STEPS);
				step_q      <= STEP_W'(DIV_STEPS - 1);
				out_value_q <= '0;
			end
			ST_EM_OUT: begin
				if (!out_stall && !pos_last) begin
					pos_q <= pos_q + CNT_W'(1);
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	assign out_valid     = (state_q == ST_EM_OUT);
	assign feature_index = FI_W'(pos_q);
	assign feature_value = out_value_q;
	assign last_feature  = pos_last;

endmodule

// ===== rtl/core/hbfv_ram.sv =====
// ----------------------------------------------------------------------------
// hbfv_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module hbfv_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/hbfv_checker.sv =====
// ----------------------------------------------------------------------------
// hbfv_checker
// Port-level checks of the hashed byte feature vector block.
// ----------------------------------------------------------------------------
module hbfv_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_write_en,
	input logic [hbfv_pkg::FC_W-1:0]   cfg_write_data,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        opcode,
	input logic [hbfv_pkg::BYTE_W-1:0] byte_value,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [hbfv_pkg::FI_W-1:0]   feature_index,
	input logic [hbfv_pkg::FV_W-1:0]   feature_value,
	input logic                        last_feature
);

	import hbfv_pkg::*;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(feature_index)
			&& $stable(feature_value) && $stable(last_feature))
		else $error("stalled result changed");

	a_value_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, feature_value} <= ONE_Q15)
		else $error("feature_value above 1.0");

	a_busy_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while emitting");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_feature |=> !out_valid && !in_stall)
		else $error("emit did not end after last transfer");

	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && opcode == OPC_BYTE |=> in_stall && !out_valid)
		else $error("byte item not processed");

endmodule

bind hashed_byte_feature_vector_top hbfv_checker u_hbfv_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hashed_byte_feature_vector_top. Prompt bytes and
// finish items are fed through the valid/stall handshake, and the bench keeps
// its own bucket store, which yields the normalized Q1.15 vector on each
// finish. Covers the empty vector, one bucket, byte extremes, feature count
// clamping, a count change in mid-prompt, random prompts under input and
// output idling, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;

	import hbfv_pkg::*;

	localparam int          CLK_HALF     = 6;
	localparam int          RESET_CYCLES = 9;
	localparam int          BUCKETS      = 64;
	localparam logic [19:0] COUNT_SAT    = 20'hFFFFF;
	localparam int          BYTE_LATENCY = 60;
	localparam int          END_CYCLES   = 200;
	localparam int          MAX_CYCLES   = 2000000;
	localparam int          MAX_REPORTS  = 10;

	typedef struct packed {
		logic [FI_W-1:0] idx;
		logic [FV_W-1:0] val;
		logic            last;
	} feature_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_write_en;
	logic [FC_W-1:0]     cfg_write_data;
	logic                in_valid;
	logic                in_stall;
	logic                opcode;
	logic [BYTE_W-1:0]   byte_value;
	logic                out_valid;
	logic                out_stall;
	logic [FI_W-1:0]     feature_index;
	logic [FV_W-1:0]     feature_value;
	logic                last_feature;

	logic [19:0]         bucket_half[BUCKETS];
	logic [FC_W-1:0]     fc_setting;
	feature_t            pending_features[$];

	int                  send_idle_pct;
	int                  recv_stall_pct;
	int                  hold_left;
	int                  cycle_count;
	int                  mismatches;
	int                  items_sent;
	int                  features_checked;
	int                  prompts_finished;

	hashed_byte_feature_vector_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.byte_value     (byte_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.feature_index  (feature_index),
		.feature_value  (feature_value),
		.last_feature   (last_feature)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("tb_top: timeout after %0d cycles", cycle_count);
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// receiver side: random stall, or a counted hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic int unsigned buckets_in_use();
		int unsigned n;
		n = 32'(fc_setting);
		if (n == 0) n = 1;
		if (n > BUCKETS) n = BUCKETS;
		return n;
	endfunction

	function automatic logic [22:0] root_floor(logic [45:0] s);
		logic [63:0] r;
		logic [63:0] t;
		int          b;
		r = 0;
		for (b = 22; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= {18'd0, s}) r = t;
		end
		return r[22:0];
	endfunction

	task automatic add_half_units(int unsigned idx, int unsigned amount);
		logic [20:0] sum;
		sum = {1'b0, bucket_half[idx]} + 21'(amount);
		bucket_half[idx] = (sum > COUNT_SAT) ? COUNT_SAT : sum[19:0];
	endtask

	task automatic update_buckets(opcode_t op, logic [BYTE_W-1:0] b);
		int unsigned n;
		logic [63:0] sq_sum;
		logic [63:0] r;
		logic [63:0] v;
		feature_t    f;
		n = buckets_in_use();
		if (op == OPC_BYTE) begin
			add_half_units(b % n, 2);
			add_half_units((b * 131 + 17) % n, 1);
		end else begin
			sq_sum = 0;
			for (int i = 0; i < n; i++) sq_sum += bucket_half[i] * bucket_half[i];
			r = 64'(root_floor(sq_sum[45:0]));
			for (int i = 0; i < n; i++) begin
				v = 0;
				if (r != 0) begin
					v = ({44'd0, bucket_half[i]} * 32768 + (r >> 1)) / r;
					if (v > 32768) v = 32768;
				end
				f.idx  = FI_W'(i);
				f.val  = v[15:0];
				f.last = (i == n - 1);
				pending_features.push_back(f);
			end
			for (int i = 0; i < BUCKETS; i++) bucket_half[i] = '0;
			prompts_finished++;
		end
	endtask

	always @(posedge clk) begin
		feature_t want;
		if (arst_n && out_valid && !out_stall) begin
			features_checked++;
			if (pending_features.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("tb_top: unexpected transfer idx=%0d val=%0d last=%0b",
						feature_index, feature_value, last_feature);
			end else begin
				want = pending_features.pop_front();
				if (feature_index !== want.idx || feature_value !== want.val ||
						last_feature !== want.last) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$write("tb_top: mismatch exp idx=%0d val=%0d last=%0b",
							want.idx, want.val, want.last);
						$display(" got idx=%0d val=%0d last=%0b",
							feature_index, feature_value, last_feature);
					end
				end
			end
		end
	end

	task automatic send_item(opcode_t op, logic [BYTE_W-1:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		opcode     <= op;
		byte_value <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
		update_buckets(op, b);
	endtask

	task automatic settle_idle();
		in_valid <= 1'b0;
		while (pending_features.size() != 0) @(posedge clk);
		repeat (BYTE_LATENCY) @(posedge clk);
	endtask

	task automatic write_feature_count(logic [FC_W-1:0] v);
		settle_idle();
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		cfg_write_en   <= 1'b0;
		fc_setting = v;
	endtask

	task automatic send_prompt(int n_bytes);
		for (int i = 0; i < n_bytes; i++)
			send_item(OPC_BYTE, BYTE_W'($urandom_range(255)));
		send_item(OPC_FINISH, BYTE_W'($urandom_range(255)));
	endtask

	task automatic test_empty_vector();
		send_item(OPC_FINISH, 8'hFF);
	endtask

	task automatic test_byte_extremes();
		send_item(OPC_BYTE, 8'h00);
		send_item(OPC_BYTE, 8'hFF);
		send_item(OPC_BYTE, 8'h01);
		send_item(OPC_BYTE, 8'h80);
		send_item(OPC_BYTE, 8'hAA);
		send_item(OPC_BYTE, 8'h55);
		send_item(OPC_FINISH, 8'h00);
	endtask

	task automatic test_single_bucket();
		write_feature_count(7'd1);
		send_item(OPC_BYTE, 8'h00);
		send_item(OPC_BYTE, 8'hFF);
		send_item(OPC_FINISH, 8'h5A);
		send_item(OPC_FINISH, 8'hA5);
	endtask

	task automatic test_count_limits();
		write_feature_count(7'd0);
		send_item(OPC_BYTE, 8'd37);
		send_item(OPC_FINISH, 8'd0);
		write_feature_count(7'd127);
		send_item(OPC_BYTE, 8'd200);
		send_item(OPC_FINISH, 8'd0);
		write_feature_count(7'd65);
		send_item(OPC_BYTE, 8'd9);
		send_item(OPC_FINISH, 8'd0);
	endtask

	task automatic test_count_change_mid_prompt();
		write_feature_count(7'd64);
		send_item(OPC_BYTE, 8'd63);
		send_item(OPC_BYTE, 8'd200);
		write_feature_count(7'd5);
		send_item(OPC_BYTE, 8'd7);
		send_item(OPC_FINISH, 8'd0);
		write_feature_count(7'd64);
		send_item(OPC_FINISH, 8'd0);
	endtask

	task automatic test_random_prompts(int budget, int in_pct, int out_pct);
		int start;
		int k;
		send_idle_pct  = in_pct;
		recv_stall_pct = out_pct;
		start = items_sent;
		while (items_sent - start < budget) begin
			if ($urandom_range(2) == 0) begin
				k = $urandom_range(99);
				if (k < 60)      write_feature_count(FC_W'($urandom_range(1, 12)));
				else if (k < 80) write_feature_count(FC_W'($urandom_range(13, 40)));
				else if (k < 92) write_feature_count(FC_W'($urandom_range(41, 64)));
				else if (k < 95) write_feature_count(7'd0);
				else             write_feature_count(FC_W'($urandom_range(65, 127)));
			end
			send_prompt($urandom_range(0, 10));
		end
	endtask

	task automatic test_output_holdoff();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_feature_count(7'd64);
		hold_left = 3000;
		send_prompt(4);
		send_prompt(3);
		settle_idle();
		send_prompt(2);
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_write_en     = 1'b0;
		cfg_write_data   = '0;
		in_valid         = 1'b0;
		opcode           = 1'b0;
		byte_value       = '0;
		out_stall        = 1'b0;
		send_idle_pct    = 0;
		recv_stall_pct   = 0;
		hold_left        = 0;
		cycle_count      = 0;
		mismatches       = 0;
		items_sent       = 0;
		features_checked = 0;
		prompts_finished = 0;
		fc_setting       = FC_RESET;
		for (int i = 0; i < BUCKETS; i++) bucket_half[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_vector();
		test_byte_extremes();
		test_single_bucket();
		test_count_limits();
		test_count_change_mid_prompt();
		test_random_prompts(24, 32, 67);
		test_random_prompts(24, 67, 32);
		test_random_prompts(24, 0, 0);
		test_output_holdoff();

		in_valid <= 1'b0;
		while (pending_features.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);

		$display("tb_top: %0d transfers in, %0d prompts finished, %0d features checked",
			items_sent, prompts_finished, features_checked);
		$display("tb_top: %0d mismatches, %0d cycles", mismatches, cycle_count);
		if (mismatches == 0 && pending_features.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
